FILE: rtl/core/bps_pkg.sv
// Package for the beep pattern sequencer: transaction types, action codes and the pattern table.
package bps_pkg;

  // Number of patterns in the table
  localparam int unsigned NUM_PATTERNS = 6;

  // Step durations in milliseconds
  localparam logic [8:0] MS_SHORT   = 9'd80;
  localparam logic [8:0] MS_GAP     = 9'd100;
  localparam logic [8:0] MS_OK_LONG = 9'd240;
  localparam logic [8:0] MS_LONG    = 9'd400;
  localparam logic [8:0] MS_ERR_GAP = 9'd150;

  // Pattern ids
  localparam logic [2:0] PAT_OK   = 3'd0;
  localparam logic [2:0] PAT_ERR  = 3'd1;
  localparam logic [2:0] PAT_DIT1 = 3'd2;
  localparam logic [2:0] PAT_DIT2 = 3'd3;
  localparam logic [2:0] PAT_DIT3 = 3'd4;
  localparam logic [2:0] PAT_LONG = 3'd5;

  // Action codes of an input transaction
  typedef enum logic [1:0] {
    ACT_PLAY = 2'd0,
    ACT_STOP = 2'd1,
    ACT_TICK = 2'd2,
    ACT_NOP  = 2'd3
  } action_t;

  // Input transaction
  typedef struct packed {
    logic [1:0] action;
    logic [2:0] pattern;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic tone_on;
    logic playing;
    logic accepted;
  } out_item_t;

  // Number of steps in a pattern; zero for invalid ids
  function automatic logic [2:0] pattern_len(input logic [2:0] pat);
    logic [2:0] len;
    case (pat)
      PAT_OK:   len = 3'd3;
      PAT_ERR:  len = 3'd3;
      PAT_DIT1: len = 3'd1;
      PAT_DIT2: len = 3'd3;
      PAT_DIT3: len = 3'd5;
      PAT_LONG: len = 3'd1;
      default:  len = 3'd0;
    endcase
    return len;
  endfunction

  // Duration of one step; zero outside the pattern
  function automatic logic [8:0] step_ms(input logic [2:0] pat, input logic [2:0] idx);
    logic [8:0] ms;
    ms = 9'd0;
    case (pat)
      PAT_OK: begin
        case (idx)
          3'd0:    ms = MS_SHORT;
          3'd1:    ms = MS_GAP;
          3'd2:    ms = MS_OK_LONG;
          default: ms = 9'd0;
        endcase
      end
      PAT_ERR: begin
        case (idx)
          3'd0:    ms = MS_LONG;
          3'd1:    ms = MS_ERR_GAP;
          3'd2:    ms = MS_LONG;
          default: ms = 9'd0;
        endcase
      end
      PAT_DIT1, PAT_LONG: begin
        if (idx == 3'd0) begin
          ms = (pat == PAT_LONG) ? MS_LONG : MS_SHORT;
        end
      end
      PAT_DIT2, PAT_DIT3: begin
        if (idx < pattern_len(pat)) begin
          ms = idx[0] ? MS_GAP : MS_SHORT;
        end
      end
      default: ms = 9'd0;
    endcase
    return ms;
  endfunction

  // Tone level of one step: even steps sound, odd steps are gaps
  function automatic logic step_tone(input logic [2:0] pat, input logic [2:0] idx);
    return (!idx[0]) && (idx < pattern_len(pat));
  endfunction

endpackage

FILE: rtl/core/bps_seq.sv
// Sequencer state and the single-pass update for one transaction.
module bps_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  bps_pkg::in_item_t  item,
  input  logic               enable,
  output bps_pkg::out_item_t result
);

  logic       busy_r,  busy_nxt;
  logic [2:0] cur_r,   cur_nxt;
  logic [2:0] idx_r,   idx_nxt;
  logic [8:0] rem_r,   rem_nxt;
  logic       tone_r,  tone_nxt;
  logic       acc;
  logic [2:0] idx_inc;

  assign idx_inc = idx_r + 3'd1;

  // Next state for the transaction in the input register
  always_comb begin
    busy_nxt = busy_r;
    cur_nxt  = cur_r;
    idx_nxt  = idx_r;
    rem_nxt  = rem_r;
    tone_nxt = tone_r;
    acc      = 1'b0;
    case (bps_pkg::action_t'(item.action))
      bps_pkg::ACT_PLAY: begin
        if ((item.pattern < 3'(bps_pkg::NUM_PATTERNS)) && enable && !busy_r) begin
          busy_nxt = 1'b1;
          cur_nxt  = item.pattern;
          idx_nxt  = 3'd0;
          rem_nxt  = bps_pkg::step_ms(item.pattern, 3'd0);
          tone_nxt = bps_pkg::step_tone(item.pattern, 3'd0);
          acc      = 1'b1;
        end
      end
      bps_pkg::ACT_STOP: begin
        busy_nxt = 1'b0;
        idx_nxt  = 3'd0;
        rem_nxt  = 9'd0;
        tone_nxt = 1'b0;
      end
      bps_pkg::ACT_TICK: begin
        if (busy_r) begin
          if (rem_r > 9'd1) begin
            rem_nxt = rem_r - 9'd1;
          end else if ((cur_r >= 3'(bps_pkg::NUM_PATTERNS)) ||
                       (idx_inc >= bps_pkg::pattern_len(cur_r))) begin
            // last step ran out: pattern done
            busy_nxt = 1'b0;
            idx_nxt  = 3'd0;
            rem_nxt  = 9'd0;
            tone_nxt = 1'b0;
          end else begin
            idx_nxt  = idx_inc;
            rem_nxt  = bps_pkg::step_ms(cur_r, idx_inc);
            tone_nxt = bps_pkg::step_tone(cur_r, idx_inc);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign result.tone_on  = tone_nxt;
  assign result.playing  = busy_nxt;
  assign result.accepted = acc;

  // State registers, updated when the transaction moves to the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cur_r  <= 3'd0;
      idx_r  <= 3'd0;
      rem_r  <= 9'd0;
      tone_r <= 1'b0;
    end else if (fire) begin
      busy_r <= busy_nxt;
      cur_r  <= cur_nxt;
      idx_r  <= idx_nxt;
      rem_r  <= rem_nxt;
      tone_r <= tone_nxt;
    end
  end

  // A playing pattern always has a valid id and step
  a_busy_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cur_r < 3'(bps_pkg::NUM_PATTERNS)) && (idx_r < bps_pkg::pattern_len(cur_r)))
    else $error("busy with invalid pattern or step");

  // Idle means silent with cleared counters
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (!tone_r && (rem_r == 9'd0) && (idx_r == 3'd0)))
    else $error("idle state not cleared");

  // An accepted play request leaves the block playing
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && acc) |=> busy_r)
    else $error("accepted play did not start pattern");

  // Tone only sounds on even steps
  a_tone_step: assert property (@(posedge clk) disable iff (!rst_n)
    tone_r |-> (busy_r && !idx_r[0]))
    else $error("tone on in a gap step");

endmodule

FILE: rtl/core/bps_out.sv
// Result register with valid/stall handshake toward the consumer.
module bps_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  bps_pkg::out_item_t res_in,
  output logic               adv,
  output logic               out_valid,
  input  logic               out_stall,
  output bps_pkg::out_item_t out_data
);

  logic               valid_r, valid_nxt;
  bps_pkg::out_item_t data_r;

  // Register can take a new result when empty or being drained
  assign adv       = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: rtl/core/beep_pattern_sequencer_unit.sv
// Top level of the beep pattern sequencer: input register, sequencer and result register.
//
// Takes one transaction per clock (play, stop or millisecond tick) and returns exactly one
// result per transaction, after it has passed the input register and the result register.
// The pattern state updates as a transaction leaves the input register, so a new
// transaction can be accepted every cycle while the consumer keeps up; a stalled result holds
// the result register, and the input register takes one more transaction before in_stall
// rises. The enable_r register (reset 1) is written through the cfg channel, which is
// always ready.
module beep_pattern_sequencer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bps_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  logic               s1_valid_r, s1_valid_nxt;
  bps_pkg::in_item_t  s1_data_r;
  logic               enable_r;
  logic               adv;
  logic               fire;
  logic               in_acc;
  bps_pkg::out_item_t result;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      enable_r <= cfg_data;
    end
  end

  // Input register
  assign fire         = s1_valid_r && adv;
  assign in_stall     = s1_valid_r && !adv;
  assign in_acc       = in_valid && !in_stall;
  assign s1_valid_nxt = in_acc ? 1'b1 : (s1_valid_r && !fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
  end

  // Pattern sequencer
  bps_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_data_r),
    .enable (enable_r),
    .result (result)
  );

  // Result register
  bps_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res_in    (result),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Stall only holds back a transaction that is really waiting
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid && out_stall))
    else $error("input stalled without a blocked pipeline");

  // A transaction leaving the input register shows up as a result next cycle
  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("moved transaction lost");

  // A held input transaction stays while it cannot advance
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> s1_valid_r)
    else $error("input transaction dropped");

endmodule

FILE: dv/bps_checker.sv
// Checker for the beep pattern sequencer: watches all channels, predicts results and compares.
module bps_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  bps_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  bps_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 checked,
  output int                 started
);

  import bps_pkg::*;

  // Predicted sequencer state
  logic       enable_m;
  logic       busy_m;
  logic [2:0] pat_m;
  logic [2:0] step_m;
  logic [8:0] ms_left_m;
  logic       tone_m;

  out_item_t  beep_results_q[$];

  // Duration of one step of a pattern
  function automatic logic [8:0] step_length(input logic [2:0] pat, input logic [2:0] idx);
    logic [8:0] ms;
    ms = 9'd0;
    case (pat)
      PAT_OK:             ms = (idx == 3'd0) ? 9'd80 : (idx == 3'd1) ? 9'd100 : 9'd240;
      PAT_ERR:            ms = (idx == 3'd1) ? 9'd150 : 9'd400;
      PAT_DIT1:           ms = 9'd80;
      PAT_DIT2, PAT_DIT3: ms = idx[0] ? 9'd100 : 9'd80;
      PAT_LONG:           ms = 9'd400;
      default:            ms = 9'd0;
    endcase
    return ms;
  endfunction

  // Number of steps in a pattern
  function automatic logic [2:0] steps_in(input logic [2:0] pat);
    logic [2:0] n;
    case (pat)
      PAT_OK, PAT_ERR, PAT_DIT2: n = 3'd3;
      PAT_DIT1, PAT_LONG:        n = 3'd1;
      PAT_DIT3:                  n = 3'd5;
      default:                   n = 3'd0;
    endcase
    return n;
  endfunction

  task automatic silence_sequencer();
    busy_m    = 1'b0;
    tone_m    = 1'b0;
    step_m    = 3'd0;
    ms_left_m = 9'd0;
  endtask

  // Advance the predicted sequencer by one transaction and form its result
  task automatic advance_sequencer(input in_item_t it, output out_item_t res);
    logic acc;
    acc = 1'b0;
    case (action_t'(it.action))
      ACT_PLAY: begin
        if (it.pattern < NUM_PATTERNS && enable_m && !busy_m) begin
          pat_m     = it.pattern;
          step_m    = 3'd0;
          busy_m    = 1'b1;
          tone_m    = 1'b1;
          ms_left_m = step_length(it.pattern, 3'd0);
          acc       = 1'b1;
        end
      end
      ACT_STOP: silence_sequencer();
      ACT_TICK: begin
        if (busy_m) begin
          if (ms_left_m > 9'd1) begin
            ms_left_m = ms_left_m - 9'd1;
          end else begin
            step_m = step_m + 3'd1;
            if (step_m >= steps_in(pat_m)) begin
              silence_sequencer();
            end else begin
              // even steps sound, odd steps are gaps
              tone_m    = ~step_m[0];
              ms_left_m = step_length(pat_m, step_m);
            end
          end
        end
      end
      default: ;
    endcase
    res.tone_on  = tone_m;
    res.playing  = busy_m;
    res.accepted = acc;
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    fail_count++;
  endtask

  // Channel monitor: results are compared before new transactions are predicted
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      enable_m = 1'b1;
      pat_m    = 3'd0;
      silence_sequencer();
      beep_results_q.delete();
      fail_count = 0;
      checked    = 0;
      started    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        enable_m = cfg_data;
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (beep_results_q.size() == 0) begin
          report_mismatch($sformatf("result %b with no transaction pending", got));
        end else begin
          want = beep_results_q.pop_front();
          if (got.tone_on !== want.tone_on)
            report_mismatch($sformatf("result %0d tone_on exp %b got %b",
                                      checked, want.tone_on, got.tone_on));
          if (got.playing !== want.playing)
            report_mismatch($sformatf("result %0d playing exp %b got %b",
                                      checked, want.playing, got.playing));
          if (got.accepted !== want.accepted)
            report_mismatch($sformatf("result %0d accepted exp %b got %b",
                                      checked, want.accepted, got.accepted));
        end
        checked++;
      end
      if (in_valid && !in_stall) begin
        advance_sequencer(in_data, want);
        if (want.accepted) started++;
        beep_results_q.push_back(want);
      end
    end
    pending = beep_results_q.size();
  end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the beep pattern sequencer: clock, reset, stimulus and verdict.
module tb_top;

  import bps_pkg::*;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 200;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b1;

  int fail_count;
  int pending;
  int checked;
  int started;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req      = 1'b0;
  int items_sent    = 0;
  int idle_run;

  beep_pattern_sequencer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  bps_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .started    (started)
  );

  // Clock: period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: random stall, or a long counted hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: cycles in a row with no transaction on any channel
  initial begin
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("Watchdog expired with %0d results outstanding", pending);
    $display("FAIL");
    $finish;
  end

  // Offer one transaction, with an optional random gap first, and wait for acceptance
  task automatic send_item(input action_t act, input logic [2:0] pat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data.action <= act;
    in_data.pattern <= pat;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stop offering and wait until every predicted result has been seen
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_enable(input logic value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_noise();
    send_item(action_t'($urandom_range(3)), 3'($urandom_range(7)));
  endtask

  // Total tick count of a full pattern
  function automatic int pattern_total_ms(input logic [2:0] pat);
    int total;
    case (pat)
      PAT_OK:   total = 420;
      PAT_ERR:  total = 950;
      PAT_DIT1: total = 80;
      PAT_DIT2: total = 260;
      PAT_DIT3: total = 440;
      default:  total = 400;
    endcase
    return total;
  endfunction

  // One play request followed by ticks, cut to the given item budget; short patterns are favored
  task automatic play_random_sequence(input int budget);
    logic [2:0] pat;
    int         pick;
    int         ticks;
    bit         full;
    pick = $urandom_range(9);
    case (pick)
      5:       pat = PAT_DIT2;
      6:       pat = PAT_OK;
      7:       pat = PAT_DIT3;
      8:       pat = PAT_LONG;
      9:       pat = PAT_ERR;
      default: pat = PAT_DIT1;
    endcase
    full  = ($urandom_range(9) < 7);
    ticks = full ? pattern_total_ms(pat) + $urandom_range(3)
                 : $urandom_range(pattern_total_ms(pat), 1);
    if (ticks > budget - 1) ticks = budget - 1;
    send_item(ACT_PLAY, pat);
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(99) < 4)
        send_noise();
      else
        send_item(ACT_TICK, 3'($urandom_range(7)));
    end
    if (!full && $urandom_range(1)) send_item(ACT_STOP, 3'($urandom_range(7)));
  endtask

  // Stimulus
  initial begin
    int phase_start;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 23;
    recv_idle_pct = 75;

    // Directed: idle corner cases, invalid ids, busy refusal, every pattern, stop
    send_item(ACT_TICK, 3'd0);
    send_item(ACT_STOP, 3'd0);
    send_item(ACT_NOP, 3'd7);
    send_item(ACT_PLAY, 3'd6);
    send_item(ACT_PLAY, 3'd7);
    send_item(ACT_PLAY, PAT_DIT1);
    send_item(ACT_PLAY, PAT_LONG);
    send_item(ACT_TICK, 3'd7);
    send_item(ACT_NOP, 3'd0);
    send_item(ACT_STOP, 3'd5);
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      send_item(ACT_PLAY, 3'(p));
      send_item(ACT_STOP, 3'd0);
    end
    // Plays refused while the buzzer is disabled
    write_enable(1'b0);
    send_item(ACT_PLAY, PAT_OK);
    send_item(ACT_PLAY, PAT_LONG);
    send_item(ACT_TICK, 3'd0);
    write_enable(1'b1);
    send_item(ACT_PLAY, PAT_DIT3);
    send_item(ACT_STOP, 3'd0);

    // Random phases with three idle mixes; the last adds a long receiver hold-off
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 23; recv_idle_pct = 75; end
        1: begin send_idle_pct = 75; recv_idle_pct = 23; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_enable(1'b0);
      repeat (8) send_noise();
      write_enable(1'b1);
      if (phase == 2) hold_req = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        if ($urandom_range(9) < 8)
          play_random_sequence(ITEMS_PER_PHASE - (items_sent - phase_start));
        else
          repeat ($urandom_range(6, 1)) send_noise();
      end
    end

    wait_for_results();
    repeat (4) @(posedge clk);

    $display("Covered %0d transactions, %0d patterns started, %0d results checked.",
             items_sent, started, checked);
    $display("Idle mixes 23/75, 75/23 and none, with a %0d-cycle result hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: beep_pattern_sequencer_unit.f
rtl/core/bps_pkg.sv
rtl/core/bps_seq.sv
rtl/core/bps_out.sv
rtl/core/beep_pattern_sequencer_unit.sv
dv/bps_checker.sv
dv/tb_top.sv
